### design/depth_background_subtract_roi_top_macros.svh
// Assertion macros used by the checker file.
`ifndef DEPTH_BACKGROUND_SUBTRACT_ROI_TOP_MACROS_SVH
`define DEPTH_BACKGROUND_SUBTRACT_ROI_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define DRBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drbs assertion failed");

// Next-cycle implication, off during reset.
`define DRBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drbs assertion failed");

`endif

### design/drbs_pkg.sv
// Shared constants and types for the depth background subtraction block.
package drbs_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;
  localparam int NPIX         = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(NPIX);

  localparam int X_W        = 10;
  localparam int Y_W        = 9;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int DIFF_W     = 17;
  localparam int THR_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hFF;
  localparam logic [COLOR_W-1:0] COLOR_MIN = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROI_LEFT        = 3'd0,
    CFG_ROI_TOP         = 3'd1,
    CFG_ROI_WIDTH       = 3'd2,
    CFG_ROI_HEIGHT      = 3'd3,
    CFG_DEPTH_THRESHOLD = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [X_W-1:0]   roi_left;
    logic [Y_W-1:0]   roi_top;
    logic [X_W-1:0]   roi_width;
    logic [Y_W-1:0]   roi_height;
    logic [THR_W-1:0] depth_threshold;
  } cfg_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic               store;      // capture inside the frame
    logic               set_valid;  // capture of the bottom right pixel
    logic               check;      // process inside frame and rectangle
    logic [ADDR_W-1:0]  addr;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } cmd_t;

endpackage

### design/drbs_queue.sv
// Small request queue between the front and back parts.
module drbs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  drbs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output drbs_pkg::cmd_t head_cmd
);
  import drbs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### design/drbs_front.sv
// Front part: accepts pixels, classifies them and forms the memory address.
module drbs_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [drbs_pkg::X_W-1:0]        pix_x,
  input  logic [drbs_pkg::Y_W-1:0]        pix_y,
  input  logic [drbs_pkg::DEPTH_W-1:0]    depth_in,
  input  logic [drbs_pkg::COLOR_W-1:0]    red_in,
  input  logic [drbs_pkg::COLOR_W-1:0]    green_in,
  input  logic [drbs_pkg::COLOR_W-1:0]    blue_in,
  input  drbs_pkg::cfg_t                  cfg,
  input  logic                            q_full,
  output logic                            push,
  output drbs_pkg::cmd_t                  push_cmd
);
  import drbs_pkg::*;

  logic         in_frame;
  logic         last_pix;
  logic         in_rect;
  logic [X_W:0] right_edge;
  logic [Y_W:0] bottom_edge;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    in_frame    = (32'(pix_x) < 32'(FRAME_WIDTH)) && (32'(pix_y) < 32'(FRAME_HEIGHT));
    last_pix    = (32'(pix_x) == 32'(FRAME_WIDTH - 1)) &&
                  (32'(pix_y) == 32'(FRAME_HEIGHT - 1));
    // exclusive bounds, sums kept one bit wider so they never wrap
    right_edge  = {1'b0, cfg.roi_left} + {1'b0, cfg.roi_width};
    bottom_edge = {1'b0, cfg.roi_top} + {1'b0, cfg.roi_height};
    in_rect     = (pix_x > cfg.roi_left) && ({1'b0, pix_x} < right_edge) &&
                  (pix_y > cfg.roi_top) && ({1'b0, pix_y} < bottom_edge);

    push_cmd.store     = (op == OP_CAPTURE) && in_frame;
    push_cmd.set_valid = (op == OP_CAPTURE) && in_frame && last_pix;
    push_cmd.check     = (op == OP_PROCESS) && in_frame && in_rect;
    push_cmd.addr      = ADDR_W'(pix_y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(pix_x);
    push_cmd.depth     = depth_in;
    push_cmd.red       = red_in;
    push_cmd.green     = green_in;
    push_cmd.blue      = blue_in;
  end

endmodule

### design/drbs_back.sv
// Back part: background memory, subtraction, threshold and output register.
module drbs_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  drbs_pkg::cmd_t                        q_cmd,
  output logic                                  q_pop,
  input  logic [drbs_pkg::THR_W-1:0]            depth_threshold,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [drbs_pkg::COLOR_W-1:0]          mask_out,
  output logic [drbs_pkg::COLOR_W-1:0]          red_out,
  output logic [drbs_pkg::COLOR_W-1:0]          green_out,
  output logic [drbs_pkg::COLOR_W-1:0]          blue_out,
  output logic signed [drbs_pkg::DIFF_W-1:0]    depth_diff,
  output logic                                  diff_valid
);
  import drbs_pkg::*;

  logic [DEPTH_W-1:0] bg_mem [NPIX];
  logic [DEPTH_W-1:0] rd_data;
  logic               bg_valid;

  logic               s1_valid;
  cmd_t               s1_cmd;
  logic               s1_check;

  logic               out_load;
  logic               s1_ready;
  logic signed [DIFF_W-1:0] diff;
  logic               mark;

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign s1_ready = !s1_valid || out_load;
  assign q_pop    = q_valid && s1_ready;

  // background store: capture writes, in-rectangle process reads
  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.store) begin
      bg_mem[q_cmd.addr] <= q_cmd.depth;
    end
    if (q_pop && q_cmd.check) begin
      rd_data <= bg_mem[q_cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd   <= q_cmd;
      s1_check <= q_cmd.check && bg_valid;
    end
  end

  always_comb begin
    diff = $signed({1'b0, rd_data}) - $signed({1'b0, s1_cmd.depth});
    mark = s1_check && (diff > $signed({{(DIFF_W - THR_W){1'b0}}, depth_threshold}));
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mask_out   <= mark ? COLOR_MAX : COLOR_MIN;
      red_out    <= mark ? COLOR_MAX : s1_cmd.red;
      green_out  <= mark ? COLOR_MAX : s1_cmd.green;
      blue_out   <= mark ? COLOR_MIN : s1_cmd.blue;
      depth_diff <= s1_check ? diff : '0;
      diff_valid <= s1_check;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && q_cmd.set_valid) begin
        bg_valid <= 1'b1;
      end
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/depth_background_subtract_roi_top.sv
// Top level of the depth background subtraction block with rectangle of interest.
//
// Use:
//   Input channel (in_valid/in_ready) carries one pixel request: op (process or
//   capture), pix_x/pix_y, depth_in and the RGB color. Output channel
//   (out_valid/out_ready) returns one result per request, in order: mask, color,
//   depth_diff and diff_valid. Configuration registers are written through
//   cfg_wr_en/cfg_index/cfg_data while the block is idle; index 0..4 selects
//   roi_left, roi_top, roi_width, roi_height, depth_threshold.
// Path: an accepted request goes through the queue, the background memory read
//   and the result register before it is offered at out_valid.
// Throughput: one request per cycle sustained while out_ready is high; the
//   background memory has one port; a request makes at most one write or read.
// Reset: background marked invalid, queue and pipeline emptied, registers back
//   to 100/100/100/100/10. Background memory contents are not cleared.
// Stall: when out_ready is low the result register holds, the pipeline stage
//   behind it fills, then the 4-entry queue fills and in_ready drops.
module depth_background_subtract_roi_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [drbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [drbs_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  op,
  input  logic [drbs_pkg::X_W-1:0]              pix_x,
  input  logic [drbs_pkg::Y_W-1:0]              pix_y,
  input  logic [drbs_pkg::DEPTH_W-1:0]          depth_in,
  input  logic [drbs_pkg::COLOR_W-1:0]          red_in,
  input  logic [drbs_pkg::COLOR_W-1:0]          green_in,
  input  logic [drbs_pkg::COLOR_W-1:0]          blue_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [drbs_pkg::COLOR_W-1:0]          mask_out,
  output logic [drbs_pkg::COLOR_W-1:0]          red_out,
  output logic [drbs_pkg::COLOR_W-1:0]          green_out,
  output logic [drbs_pkg::COLOR_W-1:0]          blue_out,
  output logic signed [drbs_pkg::DIFF_W-1:0]    depth_diff,
  output logic                                  diff_valid
);
  import drbs_pkg::*;

  cfg_t cfg;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roi_left        <= X_W'(100);
      cfg.roi_top         <= Y_W'(100);
      cfg.roi_width       <= X_W'(100);
      cfg.roi_height      <= Y_W'(100);
      cfg.depth_threshold <= THR_W'(10);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROI_LEFT:        cfg.roi_left        <= cfg_data[X_W-1:0];
        CFG_ROI_TOP:         cfg.roi_top         <= cfg_data[Y_W-1:0];
        CFG_ROI_WIDTH:       cfg.roi_width       <= cfg_data[X_W-1:0];
        CFG_ROI_HEIGHT:      cfg.roi_height      <= cfg_data[Y_W-1:0];
        CFG_DEPTH_THRESHOLD: cfg.depth_threshold <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  drbs_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .pix_x    (pix_x),
    .pix_y    (pix_y),
    .depth_in (depth_in),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  drbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  drbs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .depth_threshold (cfg.depth_threshold),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .mask_out        (mask_out),
    .red_out         (red_out),
    .green_out       (green_out),
    .blue_out        (blue_out),
    .depth_diff      (depth_diff),
    .diff_valid      (diff_valid)
  );

endmodule

### design/drbs_checker.sv
// Port-level checker for the depth background subtraction block, with its bind.
`include "depth_background_subtract_roi_top_macros.svh"

module drbs_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [drbs_pkg::COLOR_W-1:0]          mask_out,
  input logic [drbs_pkg::COLOR_W-1:0]          red_out,
  input logic [drbs_pkg::COLOR_W-1:0]          green_out,
  input logic [drbs_pkg::COLOR_W-1:0]          blue_out,
  input logic signed [drbs_pkg::DIFF_W-1:0]    depth_diff,
  input logic                                  diff_valid
);
  import drbs_pkg::*;

  // a stalled result stays valid and keeps its mask, depth_diff, red and blue
  `DRBS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(mask_out) && $stable(depth_diff) && $stable(red_out) && $stable(blue_out))

  // mask is all or nothing
  `DRBS_ASSERT_NOW(a_mask_code, clk, rst, out_valid, mask_out == COLOR_MAX || mask_out == COLOR_MIN)

  // a marked pixel is yellow, checked and has a positive difference
  `DRBS_ASSERT_NOW(a_mark_color, clk, rst, out_valid && mask_out == COLOR_MAX, red_out == COLOR_MAX && green_out == COLOR_MAX && blue_out == COLOR_MIN && diff_valid && depth_diff > 0)

  // unchecked pixels report a zero difference and no mark
  `DRBS_ASSERT_NOW(a_unchecked_zero, clk, rst, out_valid && !diff_valid, depth_diff == '0 && mask_out == COLOR_MIN)

endmodule

bind depth_background_subtract_roi_top drbs_checker u_drbs_checker (.*);

### sim/tb.sv
// Testbench for the depth background subtraction block: random and directed pixel requests.
`timescale 1ns / 1ps

module tb;
  import drbs_pkg::*;

  // One pixel request as it goes into the block.
  typedef struct packed {
    logic               op;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_req_t;

  // One result as it comes out, same field order as the output ports.
  typedef struct packed {
    logic [COLOR_W-1:0]        mask;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic signed [DIFF_W-1:0]  depth_diff;
    logic                      diff_valid;
  } pixel_res_t;

  // Keeps a shadow of the background store, the valid flag and the registers,
  // and the queue of masks/colors still owed by the block.
  class mask_scoreboard;
    logic [DEPTH_W-1:0] bg_depth [int];
    int                 written_idx [$];
    bit                 bg_valid;
    cfg_t               regs;
    pixel_res_t         expected_pixels [$];
    int                 mismatches;

    function new();
      regs.roi_left        = X_W'(100);
      regs.roi_top         = Y_W'(100);
      regs.roi_width       = X_W'(100);
      regs.roi_height      = Y_W'(100);
      regs.depth_threshold = THR_W'(10);
      bg_valid             = 1'b0;
      mismatches           = 0;
    endfunction

    function void set_reg(cfg_idx_t which, logic [CFG_DATA_W-1:0] v);
      case (which)
        CFG_ROI_LEFT:        regs.roi_left        = v[X_W-1:0];
        CFG_ROI_TOP:         regs.roi_top         = v[Y_W-1:0];
        CFG_ROI_WIDTH:       regs.roi_width       = v[X_W-1:0];
        CFG_ROI_HEIGHT:      regs.roi_height      = v[Y_W-1:0];
        CFG_DEPTH_THRESHOLD: regs.depth_threshold = v[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Exclusive bounds on both sides, sums without wrap.
    function bit in_roi(int x, int y);
      int l, t, w, h;
      l = int'(regs.roi_left);
      t = int'(regs.roi_top);
      w = int'(regs.roi_width);
      h = int'(regs.roi_height);
      return x > l && x < l + w && y > t && y < t + h;
    endfunction

    function bit is_written(int idx);
      return bg_depth.exists(idx);
    endfunction

    function int stored_depth(int idx);
      return int'(bg_depth[idx]);
    endfunction

    function int threshold();
      return int'(regs.depth_threshold);
    endfunction

    function int any_written();
      return written_idx[$urandom_range(written_idx.size() - 1, 0)];
    endfunction

    // Updates the shadow state and works out the result of one request.
    function pixel_res_t predict_pixel(pixel_req_t p);
      pixel_res_t r;
      bit         in_frame;
      int         idx, bg, cur, diff, px, py;
      r.mask       = COLOR_MIN;
      r.red        = p.red;
      r.green      = p.green;
      r.blue       = p.blue;
      r.depth_diff = '0;
      r.diff_valid = 1'b0;
      px = int'(p.x);
      py = int'(p.y);
      in_frame = px < FRAME_WIDTH && py < FRAME_HEIGHT;
      idx = py * FRAME_WIDTH + px;
      if (p.op == OP_CAPTURE) begin
        if (in_frame) begin
          if (!bg_depth.exists(idx)) written_idx = {written_idx, idx};
          bg_depth[idx] = p.depth;
          if (px == FRAME_WIDTH - 1 && py == FRAME_HEIGHT - 1) bg_valid = 1'b1;
        end
      end else if (in_frame && bg_valid && in_roi(px, py)) begin
        bg   = int'(bg_depth[idx]);
        cur  = int'(p.depth);
        diff = bg - cur;
        r.diff_valid = 1'b1;
        r.depth_diff = diff[DIFF_W-1:0];
        if (diff > threshold()) begin
          r.mask  = COLOR_MAX;
          r.red   = COLOR_MAX;
          r.green = COLOR_MAX;
          r.blue  = COLOR_MIN;
        end
      end
      return r;
    endfunction

    function void note_request(pixel_req_t p);
      expected_pixels = {expected_pixels, predict_pixel(p)};
    endfunction

    function void flag(string why, pixel_res_t want, pixel_res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t %s: want mask=%0d rgb=%0d,%0d,%0d diff=%0d dv=%0b",
                  " | got mask=%0d rgb=%0d,%0d,%0d diff=%0d dv=%0b"},
                 $time, why, want.mask, want.red, want.green, want.blue, want.depth_diff,
                 want.diff_valid, got.mask, got.red, got.green, got.blue, got.depth_diff,
                 got.diff_valid);
    endfunction

    function void check_result(pixel_res_t got);
      pixel_res_t want;
      if (expected_pixels.size() == 0) begin
        flag("result with no request pending", '0, got);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.mask !== want.mask || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.depth_diff !== want.depth_diff ||
          got.diff_valid !== want.diff_valid)
        flag("result mismatch", want, got);
    endfunction

    function void flush_leftover();
      while (expected_pixels.size() != 0)
        flag("result never came", expected_pixels.pop_front(), '0);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  op = OP_PROCESS;
  logic [X_W-1:0]        pix_x = '0;
  logic [Y_W-1:0]        pix_y = '0;
  logic [DEPTH_W-1:0]    depth_in = '0;
  logic [COLOR_W-1:0]    red_in = '0;
  logic [COLOR_W-1:0]    green_in = '0;
  logic [COLOR_W-1:0]    blue_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COLOR_W-1:0]    mask_out;
  logic [COLOR_W-1:0]    red_out;
  logic [COLOR_W-1:0]    green_out;
  logic [COLOR_W-1:0]    blue_out;
  logic signed [DIFF_W-1:0] depth_diff;
  logic                  diff_valid;

  mask_scoreboard sb;

  // Idle controls for the request and result sides.
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int hold_off_cycles = 0;   // one long out_ready low stretch, consumed by the sink

  depth_background_subtract_roi_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .depth_in   (depth_in),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mask_out   (mask_out),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .depth_diff (depth_diff),
    .diff_valid (diff_valid)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drives one request at the falling edge, holds it until accepted, then
  // hands it to the scoreboard. Valid only drops when a gap is drawn.
  task automatic send_pixel(input pixel_req_t p);
    int gap;
    gap = src_idle_on ? $urandom_range(3, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {op, pix_x, pix_y, depth_in, red_in, green_in, blue_in} <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_request(p);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Every request gives a result, so an empty queue means the block is idle;
  // the extra wait after it covers the two-stage pipe.
  task automatic wait_drained();
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all five registers back to back, only called with the block idle.
  task automatic load_regs(input int l, input int t, input int w, input int h,
                           input int thr);
    cfg_idx_t order [5];
    int       vals [5];
    order = '{CFG_ROI_LEFT, CFG_ROI_TOP, CFG_ROI_WIDTH, CFG_ROI_HEIGHT,
              CFG_DEPTH_THRESHOLD};
    vals  = '{l, t, w, h, thr};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i][CFG_DATA_W-1:0];
      sb.set_reg(order[i], vals[i][CFG_DATA_W-1:0]);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic pixel_req_t req_at(logic o, int x, int y, int d, int r, int g, int b);
    pixel_req_t p;
    p.op    = o;
    p.x     = x[X_W-1:0];
    p.y     = y[Y_W-1:0];
    p.depth = d[DEPTH_W-1:0];
    p.red   = r[COLOR_W-1:0];
    p.green = g[COLOR_W-1:0];
    p.blue  = b[COLOR_W-1:0];
    return p;
  endfunction

  // Coordinate on or near a rectangle edge, or anywhere across it; kept in frame.
  function automatic int near_span(int lo, int span, int limit);
    int v;
    case ($urandom_range(4, 0))
      0: v = lo;
      1: v = lo + 1;
      2: v = lo + span - 1;
      3: v = lo + span;
      default: v = lo + $urandom_range(span, 0);
    endcase
    if (v < 0) v = 0;
    if (v >= limit) v = limit - 1;
    return v;
  endfunction

  // Position past the right or bottom edge of the frame, all port bits reachable.
  function automatic void off_frame(output int x, output int y);
    if ($urandom_range(1, 0)) begin
      x = $urandom_range(1023, FRAME_WIDTH);
      y = $urandom_range(511, 0);
    end else begin
      x = $urandom_range(1023, 0);
      y = $urandom_range(511, FRAME_HEIGHT);
    end
  endfunction

  // A captured position, preferring one inside the current rectangle.
  function automatic void pick_written(output int x, output int y);
    int idx;
    for (int i = 0; i < 6; i++) begin
      idx = sb.any_written();
      x = idx % FRAME_WIDTH;
      y = idx / FRAME_WIDTH;
      if (sb.in_roi(x, y)) break;
    end
  endfunction

  // Depth for a request; with a known background it often lands around the
  // threshold so both sides of the compare get hit.
  function automatic logic [DEPTH_W-1:0] depth_for(int idx, bit known);
    int d, delta, sel;
    sel   = $urandom_range(9, 0);
    delta = $urandom_range(4, 0);
    if (known && sel < 4)
      d = sb.stored_depth(idx) - sb.threshold() + delta - 2;
    else if (known && sel < 6)
      d = sb.stored_depth(idx);
    else if (sel == 6)
      d = 0;
    else if (sel == 7)
      d = 65535;
    else
      d = $urandom_range(65535, 0);
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return d[DEPTH_W-1:0];
  endfunction

  // Random request built from the current shadow state: ~30% captures,
  // the rest processing mostly on captured pixels.
  function automatic pixel_req_t random_pick();
    pixel_req_t p;
    int         x, y, sel;
    bit         known;
    sel     = $urandom_range(99, 0);
    p.red   = COLOR_W'($urandom_range(255, 0));
    p.green = COLOR_W'($urandom_range(255, 0));
    p.blue  = COLOR_W'($urandom_range(255, 0));
    known   = 1'b0;
    if ($urandom_range(9, 0) < 3) begin
      p.op = OP_CAPTURE;
      if (sel < 50) begin
        x = near_span(int'(sb.regs.roi_left), int'(sb.regs.roi_width), FRAME_WIDTH);
        y = near_span(int'(sb.regs.roi_top), int'(sb.regs.roi_height), FRAME_HEIGHT);
      end else if (sel < 80) begin
        x = $urandom_range(FRAME_WIDTH - 1, 0);
        y = $urandom_range(FRAME_HEIGHT - 1, 0);
      end else if (sel < 90) begin
        off_frame(x, y);
      end else begin
        // bottom right pixel: recapture while already valid
        x = FRAME_WIDTH - 1;
        y = FRAME_HEIGHT - 1;
      end
    end else begin
      p.op = OP_PROCESS;
      if (sel < 65) begin
        pick_written(x, y);
      end else if (sel < 80) begin
        x = near_span(int'(sb.regs.roi_left), int'(sb.regs.roi_width), FRAME_WIDTH);
        y = near_span(int'(sb.regs.roi_top), int'(sb.regs.roi_height), FRAME_HEIGHT);
      end else if (sel < 90) begin
        x = $urandom_range(1023, 0);
        y = $urandom_range(511, 0);
      end else begin
        off_frame(x, y);
      end
      // never make the block read a background entry nobody captured
      if (x < FRAME_WIDTH && y < FRAME_HEIGHT && sb.in_roi(x, y) &&
          !sb.is_written(y * FRAME_WIDTH + x))
        pick_written(x, y);
      known = x < FRAME_WIDTH && y < FRAME_HEIGHT && sb.is_written(y * FRAME_WIDTH + x);
    end
    p.x     = x[X_W-1:0];
    p.y     = y[Y_W-1:0];
    p.depth = depth_for(y * FRAME_WIDTH + x, known);
    return p;
  endfunction

  // Result side: draws a stall per result, or takes one long hold-off when
  // asked, then checks each accepted result at the rising edge.
  initial begin : result_sink
    pixel_res_t got;
    int         wait_cycles;
    while (rst) @(negedge clk);
    forever begin
      wait_cycles = sink_idle_on ? $urandom_range(3, 0) : 0;
      if (hold_off_cycles > 0) begin
        wait_cycles     = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {mask_out, red_out, green_out, blue_out, depth_diff, diff_valid};
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // Main sequence: reset, directed requests on reset registers, then ten
  // register settings each followed by a burst of random requests.
  initial begin : stimulus
    int l, t, w, h, thr;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part, rectangle 100..200 exclusive, threshold 10.
    send_pixel(req_at(OP_CAPTURE, 150, 150, 1000, 255, 0, 255));
    // background not valid yet: passes through even inside the rectangle
    send_pixel(req_at(OP_PROCESS, 150, 150, 900, 0, 255, 0));
    send_pixel(req_at(OP_CAPTURE, 0, 0, 0, 0, 0, 0));
    send_pixel(req_at(OP_CAPTURE, 639, 0, 65535, 255, 255, 255));
    // captures off the frame are dropped, including just below / right of the corner
    send_pixel(req_at(OP_CAPTURE, 1023, 511, 1, 1, 2, 3));
    send_pixel(req_at(OP_CAPTURE, 639, 480, 2, 4, 5, 6));
    send_pixel(req_at(OP_CAPTURE, 640, 479, 3, 7, 8, 9));
    send_pixel(req_at(OP_PROCESS, 1023, 511, 65535, 255, 255, 255));
    // bottom right capture makes the background valid
    send_pixel(req_at(OP_CAPTURE, 639, 479, 300, 10, 20, 30));
    // difference just over, at, and under the threshold, then negative
    send_pixel(req_at(OP_PROCESS, 150, 150, 989, 0, 0, 0));
    send_pixel(req_at(OP_PROCESS, 150, 150, 990, 1, 2, 3));
    send_pixel(req_at(OP_PROCESS, 150, 150, 1000, 40, 50, 60));
    send_pixel(req_at(OP_PROCESS, 150, 150, 65535, 255, 255, 255));
    // recapture while valid, then the largest positive difference
    send_pixel(req_at(OP_CAPTURE, 150, 150, 65535, 9, 9, 9));
    send_pixel(req_at(OP_PROCESS, 150, 150, 0, 128, 64, 32));
    // first and last pixels strictly inside, and both edges that are outside
    send_pixel(req_at(OP_CAPTURE, 101, 101, 50, 0, 0, 0));
    send_pixel(req_at(OP_PROCESS, 101, 101, 0, 11, 22, 33));
    send_pixel(req_at(OP_CAPTURE, 199, 199, 20, 0, 0, 0));
    send_pixel(req_at(OP_PROCESS, 199, 199, 30, 44, 55, 66));
    send_pixel(req_at(OP_CAPTURE, 100, 150, 500, 0, 0, 0));
    send_pixel(req_at(OP_PROCESS, 100, 150, 0, 77, 88, 99));
    send_pixel(req_at(OP_CAPTURE, 200, 150, 500, 0, 0, 0));
    send_pixel(req_at(OP_PROCESS, 200, 150, 0, 100, 110, 120));
    send_pixel(req_at(OP_PROCESS, 639, 479, 0, 130, 140, 150));
    send_pixel(req_at(OP_PROCESS, 640, 150, 0, 160, 170, 180));
    release_input();
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin l = 0;   t = 0;   w = 640; h = 480; thr = 0;   end  // whole frame but row and column 0
        1: begin l = 100; t = 100; w = 100; h = 100; thr = 10;  end  // reset values
        2: begin l = 640; t = 480; w = 640; h = 480; thr = 400; end  // rectangle starts off the frame
        3: begin l = 0;   t = 0;   w = 0;   h = 0;   thr = 0;   end  // empty rectangle
        default: begin
          l   = $urandom_range(620, 0);
          t   = $urandom_range(460, 0);
          w   = ($urandom_range(3, 0) == 0) ? $urandom_range(640, 0) : $urandom_range(80, 2);
          h   = ($urandom_range(3, 0) == 0) ? $urandom_range(480, 0) : $urandom_range(60, 2);
          thr = $urandom_range(400, 0);
        end
      endcase
      load_regs(l, t, w, h, thr);
      src_idle_on  = $urandom_range(3, 0) != 0;
      sink_idle_on = $urandom_range(3, 0) != 0;
      // back-pressure: the sink parks while requests keep coming, so the
      // queue fills and in_ready has to drop
      if (ph == 1 || ph == 6) begin
        hold_off_cycles = 80;
        src_idle_on     = 1'b0;
      end
      repeat (115) send_pixel(random_pick());
      release_input();
      wait_drained();
    end

    sb.flush_leftover();
    if (sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/drbs_pkg.sv
design/drbs_queue.sv
design/drbs_front.sv
design/drbs_back.sv
design/depth_background_subtract_roi_top.sv
design/drbs_checker.sv
sim/tb.sv
